// ----- rtl/core/bvg_pkg.sv -----
package bvg_pkg;

	localparam int WINDOW_SIZE = 8;
	localparam int IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam bit WIN_POW2    = (WINDOW_SIZE & (WINDOW_SIZE - 1)) == 0;

	localparam int ADC_W   = 12;
	localparam int SCALE_W = 24;
	localparam int MV_W    = 16;
	localparam int PCT_W   = 7;
	localparam int PROD_W  = ADC_W + SCALE_W;
	localparam int SUM_W   = MV_W + IDX_W;
	localparam int DIFF_W  = 23;
	localparam int DIV_W   = (SUM_W > DIFF_W) ? SUM_W : DIFF_W;
	localparam int DCNT_W  = $clog2(DIV_W + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SCALE_W;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_SCALE_Q16   = 3'd0;
	localparam cfg_idx_t REG_FULL_MV     = 3'd1;
	localparam cfg_idx_t REG_EMPTY_MV    = 3'd2;
	localparam cfg_idx_t REG_LOW_WARN_MV = 3'd3;
	localparam cfg_idx_t REG_CRITICAL_MV = 3'd4;

	localparam logic [SCALE_W-1:0] RST_SCALE_Q16   = 24'd105625;
	localparam logic [MV_W-1:0]    RST_FULL_MV     = 16'd4200;
	localparam logic [MV_W-1:0]    RST_EMPTY_MV    = 16'd3300;
	localparam logic [MV_W-1:0]    RST_LOW_WARN_MV = 16'd3500;
	localparam logic [MV_W-1:0]    RST_CRITICAL_MV = 16'd3400;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_AVG,
		ST_AVG_WAIT,
		ST_PCT,
		ST_PCT_DIV,
		ST_PCT_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic {
		DIV_AVG,
		DIV_PCT
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     mul;
		logic     sum;
		logic     avg_shift;
		logic     div_start;
		div_sel_t div_sel;
		logic     avg_from_div;
		logic     pct_eval;
		logic     pct_from_div;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic need_div;
	} sts_t;

endpackage

// ----- rtl/core/bvg_if.sv -----
interface bvg_in_if;
	import bvg_pkg::*;
	logic             valid;
	logic             ready;
	logic [ADC_W-1:0] adc_sample;
	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

interface bvg_out_if;
	import bvg_pkg::*;
	logic             valid;
	logic             ready;
	logic [MV_W-1:0]  average_mv;
	logic [PCT_W-1:0] charge_percent;
	logic             low_flag;
	logic             critical_flag;
	modport source (output valid, output average_mv, output charge_percent,
		output low_flag, output critical_flag, input ready);
	modport sink (input valid, input average_mv, input charge_percent,
		input low_flag, input critical_flag, output ready);
endinterface

interface bvg_cfg_if;
	import bvg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- rtl/core/bvg_ram.sv -----
module bvg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/core/bvg_div.sv -----
module bvg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bvg_pkg::DIV_W-1:0] dividend,
	input  logic [bvg_pkg::MV_W-1:0]  divisor,
	output logic                      done,
	output logic [bvg_pkg::DIV_W-1:0] quotient
);
	import bvg_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [MV_W-1:0]   rem_q;
	logic [MV_W-1:0]   dvs_q;
	logic [DIV_W-1:0]  quo_q;
	logic [MV_W:0]     trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? MV_W'(trial - {1'b0, dvs_q}) : trial[MV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ----- rtl/core/bvg_datapath.sv -----
module bvg_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bvg_pkg::cmd_t                  cmd,
	output bvg_pkg::sts_t                  sts,
	input  logic                           cfg_we,
	input  bvg_pkg::cfg_idx_t              cfg_idx,
	input  logic [bvg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [bvg_pkg::ADC_W-1:0]      adc_sample,
	output logic [bvg_pkg::MV_W-1:0]       average_mv,
	output logic [bvg_pkg::PCT_W-1:0]      charge_percent,
	output logic                           low_flag,
	output logic                           critical_flag
);
	import bvg_pkg::*;

	logic [SCALE_W-1:0]     scale_q;
	logic [MV_W-1:0]        full_q;
	logic [MV_W-1:0]        empty_q;
	logic [MV_W-1:0]        lowth_q;
	logic [MV_W-1:0]        critth_q;

	logic [ADC_W-1:0]       adc_q;
	logic [PROD_W-1:0]      prod_q;
	logic [SUM_W-1:0]       sum_q;
	logic [IDX_W-1:0]       widx_q;
	logic [WINDOW_SIZE-1:0] vld_q;
	logic [MV_W-1:0]        avg_q;
	logic [DIFF_W-1:0]      diff_q;
	logic [PCT_W-1:0]       pct_q;
	logic                   low_q;
	logic                   crit_q;

	logic [MV_W-1:0]        out_avg_q;
	logic [PCT_W-1:0]       out_pct_q;
	logic                   out_low_q;
	logic                   out_crit_q;

	logic [MV_W-1:0]        ram_rdata;
	logic [MV_W-1:0]        old_mv;
	logic [MV_W-1:0]        new_mv;
	logic                   ge_full;
	logic                   le_empty;
	logic [DIV_W-1:0]       div_dividend;
	logic [MV_W-1:0]        div_divisor;
	logic [DIV_W-1:0]       div_quo;
	logic                   div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= RST_SCALE_Q16;
			full_q   <= RST_FULL_MV;
			empty_q  <= RST_EMPTY_MV;
			lowth_q  <= RST_LOW_WARN_MV;
			critth_q <= RST_CRITICAL_MV;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SCALE_Q16:   scale_q  <= cfg_data;
				REG_FULL_MV:     full_q   <= cfg_data[MV_W-1:0];
				REG_EMPTY_MV:    empty_q  <= cfg_data[MV_W-1:0];
				REG_LOW_WARN_MV: lowth_q  <= cfg_data[MV_W-1:0];
				REG_CRITICAL_MV: critth_q <= cfg_data[MV_W-1:0];
				default: ;
			endcase
		end
	end

	bvg_ram #(
		.WIDTH(MV_W),
		.DEPTH(WINDOW_SIZE)
	) u_ring (
		.clk   (clk),
		.we    (cmd.sum),
		.waddr (widx_q),
		.wdata (new_mv),
		.re    (cmd.capture),
		.raddr (widx_q),
		.rdata (ram_rdata)
	);

	// unwritten slots read as zero
	assign old_mv = vld_q[widx_q] ? ram_rdata : '0;
	assign new_mv = (|prod_q[PROD_W-1:16+MV_W]) ? '1 : prod_q[16 +: MV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			widx_q <= '0;
			vld_q  <= '0;
		end else if (cmd.sum) begin
			sum_q         <= sum_q - SUM_W'(old_mv) + SUM_W'(new_mv);
			vld_q[widx_q] <= 1'b1;
			widx_q        <= (widx_q == IDX_W'(WINDOW_SIZE - 1)) ? '0 : widx_q + 1'b1;
		end
	end

	assign ge_full      = avg_q >= full_q;
	assign le_empty     = avg_q <= empty_q;
	assign sts.need_div = !ge_full && !le_empty;
	assign sts.div_done = div_done;

	assign div_dividend = (cmd.div_sel == DIV_AVG) ? DIV_W'(sum_q) : DIV_W'(diff_q);
	assign div_divisor  = (cmd.div_sel == DIV_AVG) ? MV_W'(WINDOW_SIZE) : full_q - empty_q;

	bvg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			adc_q <= adc_sample;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(adc_q) * PROD_W'(scale_q);
		end
		if (cmd.avg_shift) begin
			avg_q <= sum_q[IDX_W +: MV_W];
		end else if (cmd.avg_from_div) begin
			avg_q <= div_quo[MV_W-1:0];
		end
		if (cmd.pct_eval) begin
			diff_q <= DIFF_W'(avg_q - empty_q) * DIFF_W'(PCT_FULL);
			pct_q  <= ge_full ? PCT_FULL : '0;
			low_q  <= avg_q < lowth_q;
			crit_q <= avg_q < critth_q;
		end else if (cmd.pct_from_div) begin
			pct_q <= div_quo[PCT_W-1:0];
		end
		if (cmd.out_load) begin
			out_avg_q  <= avg_q;
			out_pct_q  <= pct_q;
			out_low_q  <= low_q;
			out_crit_q <= crit_q;
		end
	end

	assign average_mv     = out_avg_q;
	assign charge_percent = out_pct_q;
	assign low_flag       = out_low_q;
	assign critical_flag  = out_crit_q;
endmodule

// ----- rtl/core/bvg_ctrl.sv -----
module bvg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	output bvg_pkg::cmd_t cmd,
	input  bvg_pkg::sts_t sts
);
	import bvg_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   load_ok;

	assign load_ok = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_MUL;
			ST_MUL:      state_d = ST_SUM;
			ST_SUM:      state_d = ST_AVG;
			ST_AVG:      state_d = WIN_POW2 ? ST_PCT : ST_AVG_WAIT;
			ST_AVG_WAIT: if (sts.div_done) state_d = ST_PCT;
			ST_PCT:      state_d = sts.need_div ? ST_PCT_DIV : ST_OUT;
			ST_PCT_DIV:  state_d = ST_PCT_WAIT;
			ST_PCT_WAIT: if (sts.div_done) state_d = ST_OUT;
			ST_OUT:      if (load_ok) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_SUM: cmd.sum = 1'b1;
			ST_AVG: begin
				cmd.avg_shift = WIN_POW2;
				cmd.div_start = !WIN_POW2;
				cmd.div_sel   = DIV_AVG;
			end
			ST_AVG_WAIT: begin
				cmd.div_sel      = DIV_AVG;
				cmd.avg_from_div = sts.div_done;
			end
			ST_PCT: cmd.pct_eval = 1'b1;
			ST_PCT_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_PCT;
			end
			ST_PCT_WAIT: begin
				cmd.div_sel      = DIV_PCT;
				cmd.pct_from_div = sts.div_done;
			end
			ST_OUT: cmd.out_load = load_ok;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

// ----- rtl/core/battery_voltage_average_gauge.sv -----
// Moving-average battery gauge. Each input transaction carries one 12-bit ADC
// sample, which is scaled to millivolts ((sample * scale_q16) >> 16, saturated
// at 65535) and averaged over the last WINDOW_SIZE samples; the ring starts at
// zero, so the first averages include zeros. Each sample yields exactly one
// result: the average, a 0..100 charge estimate clamped at full_mv/empty_mv,
// and low/critical flags. One sample is processed at a time: with a window
// of 8 it passes the capture, multiply, sum, average, percent and output
// states, plus a divider pass when the average lies strictly between empty
// and full: a start state, DIV_W = 23 bit-serial divider steps and a state
// to take the quotient. A non-power-of-two window adds a divider pass for
// the average. A finished result sits in an output register, so the next
// sample is taken while it waits. The user must write registers through
// the configuration channel only while no sample is in flight; not enforced.
module battery_voltage_average_gauge (
	input logic       clk,
	input logic       arst_n,
	bvg_in_if.sink    in_ch,
	bvg_out_if.source out_ch,
	bvg_cfg_if.sink   cfg_ch
);
	import bvg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ch.ready = 1'b1;

	bvg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	bvg_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_ch.valid),
		.cfg_idx        (cfg_ch.reg_index),
		.cfg_data       (cfg_ch.wdata),
		.adc_sample     (in_ch.adc_sample),
		.average_mv     (out_ch.average_mv),
		.charge_percent (out_ch.charge_percent),
		.low_flag       (out_ch.low_flag),
		.critical_flag  (out_ch.critical_flag)
	);
endmodule

// ----- rtl/core/bvg_checker.sv -----
module bvg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bvg_pkg::MV_W-1:0]      average_mv,
	input logic [bvg_pkg::PCT_W-1:0]     charge_percent,
	input logic                          low_flag,
	input logic                          critical_flag
);
	import bvg_pkg::*;

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> charge_percent <= PCT_FULL)
		else $error("charge_percent above full scale");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second sample taken while one is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(average_mv) && $stable(charge_percent)
			&& $stable(low_flag) && $stable(critical_flag)))
		else $error("stalled result changed");
endmodule

bind battery_voltage_average_gauge bvg_checker u_bvg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.average_mv     (out_ch.average_mv),
	.charge_percent (out_ch.charge_percent),
	.low_flag       (out_ch.low_flag),
	.critical_flag  (out_ch.critical_flag)
);
